>>> hw/rtl/dsv_pkg.sv
// Package for the date string validator.
// Holds field widths, status and register codes, character constants and
// the date record (parse to check) and the current-date settings struct.
package dsv_pkg;

    localparam int CH_W     = 8;
    localparam int YEAR_W   = 14;
    localparam int MD_W     = 7;
    localparam int POS_W    = 4;
    localparam int STATUS_W = 2;
    localparam int DIGIT_W  = 4;

    localparam int TMONTH_W = 4;
    localparam int TDAY_W   = 5;
    localparam int AGE_W    = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 14;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_LENGTH = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_TODAY_YEAR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TODAY_MONTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TODAY_DAY   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_AGE_LIMIT   = 2'd3;

    localparam logic [YEAR_W-1:0]   RST_TODAY_YEAR  = 14'd2000;
    localparam logic [TMONTH_W-1:0] RST_TODAY_MONTH = 4'd1;
    localparam logic [TDAY_W-1:0]   RST_TODAY_DAY   = 5'd1;
    localparam logic [AGE_W-1:0]    RST_AGE_LIMIT   = 8'd0;

    localparam logic [CH_W-1:0] CHAR_DOT  = 8'h2E;
    localparam logic [CH_W-1:0] CHAR_ZERO = 8'h30;
    localparam logic [CH_W-1:0] CHAR_NINE = 8'h39;

    localparam logic [POS_W-1:0] POS_YEAR_HI_END = 4'd2;
    localparam logic [POS_W-1:0] POS_DOT_A       = 4'd4;
    localparam logic [POS_W-1:0] POS_DOT_B       = 4'd7;
    localparam logic [POS_W-1:0] POS_DATE_LEN    = 4'd10;
    localparam logic [POS_W-1:0] POS_SAT         = 4'd11;

    localparam logic [MD_W-1:0] MONTHS_PER_YEAR = 7'd12;
    localparam logic [MD_W-1:0] MONTH_FEB       = 7'd2;
    localparam logic [MD_W-1:0] DAYS_31 = 7'd31;
    localparam logic [MD_W-1:0] DAYS_30 = 7'd30;
    localparam logic [MD_W-1:0] DAYS_29 = 7'd29;
    localparam logic [MD_W-1:0] DAYS_28 = 7'd28;

    typedef struct packed {
        logic              len_ok;
        logic              fmt_bad;
        logic              leap;
        logic [YEAR_W-1:0] year;
        logic [MD_W-1:0]   month;
        logic [MD_W-1:0]   day;
    } date_rec_t;

    typedef struct packed {
        logic [YEAR_W-1:0]   year;
        logic [TMONTH_W-1:0] month;
        logic [TDAY_W-1:0]   day;
        logic [AGE_W-1:0]    age_limit;
    } today_cfg_t;

endpackage

>>> hw/rtl/dsv_parse.sv
// Character parser: position count, format flag and decimal accumulators.
// Emits one registered date record per string. Depends on dsv_pkg.
module dsv_parse import dsv_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic [CH_W-1:0] s_ch,
    input  logic            s_last,
    output logic            rec_valid,
    output date_rec_t       rec,
    input  logic            rec_take
);

    logic [POS_W-1:0]  pos_reg,     pos_next;
    logic              bad_reg,     bad_next;
    logic [YEAR_W-1:0] year_reg,    year_next;
    logic [MD_W-1:0]   year_hi_reg, year_hi_next;
    logic [MD_W-1:0]   year_lo_reg, year_lo_next;
    logic [MD_W-1:0]   month_reg,   month_next;
    logic [MD_W-1:0]   day_reg,     day_next;
    logic              rec_valid_reg, rec_valid_next;
    date_rec_t         rec_reg,     rec_next;

    logic [POS_W-1:0]  step_pos;
    logic              step_bad;
    logic [YEAR_W-1:0] step_year;
    logic [MD_W-1:0]   step_hi, step_lo, step_month, step_day;
    logic              is_digit;
    logic [DIGIT_W-1:0] dv;
    logic              s_accept;

    function automatic logic [YEAR_W-1:0] times10_add(input logic [YEAR_W-1:0] a,
                                                      input logic [DIGIT_W-1:0] d);
        times10_add = (a << 3) + (a << 1) + {{(YEAR_W-DIGIT_W){1'b0}}, d};
    endfunction

    assign s_ready  = !rec_valid_reg || rec_take;
    assign s_accept = s_valid && s_ready;
    assign is_digit = (s_ch >= CHAR_ZERO) && (s_ch <= CHAR_NINE);

    always_comb begin
        logic [CH_W-1:0] diff;
        diff = s_ch - CHAR_ZERO;
        dv   = is_digit ? diff[DIGIT_W-1:0] : '0;
    end

    always_comb begin
        logic [YEAR_W-1:0] t;
        step_pos   = pos_reg;
        step_bad   = bad_reg;
        step_year  = year_reg;
        step_hi    = year_hi_reg;
        step_lo    = year_lo_reg;
        step_month = month_reg;
        step_day   = day_reg;
        t          = '0;
        if (pos_reg < POS_DATE_LEN) begin
            if (pos_reg == POS_DOT_A || pos_reg == POS_DOT_B) begin
                if (s_ch != CHAR_DOT) begin
                    step_bad = 1'b1;
                end
            end else begin
                if (!is_digit) begin
                    step_bad = 1'b1;
                end
                if (pos_reg < POS_DOT_A) begin
                    step_year = times10_add(year_reg, dv);
                    if (pos_reg < POS_YEAR_HI_END) begin
                        t       = times10_add({{(YEAR_W-MD_W){1'b0}}, year_hi_reg}, dv);
                        step_hi = t[MD_W-1:0];
                    end else begin
                        t       = times10_add({{(YEAR_W-MD_W){1'b0}}, year_lo_reg}, dv);
                        step_lo = t[MD_W-1:0];
                    end
                end else if (pos_reg < POS_DOT_B) begin
                    t          = times10_add({{(YEAR_W-MD_W){1'b0}}, month_reg}, dv);
                    step_month = t[MD_W-1:0];
                end else begin
                    t        = times10_add({{(YEAR_W-MD_W){1'b0}}, day_reg}, dv);
                    step_day = t[MD_W-1:0];
                end
            end
        end
        if (pos_reg < POS_SAT) begin
            step_pos = pos_reg + POS_W'(1);
        end
    end

    always_comb begin
        pos_next       = pos_reg;
        bad_next       = bad_reg;
        year_next      = year_reg;
        year_hi_next   = year_hi_reg;
        year_lo_next   = year_lo_reg;
        month_next     = month_reg;
        day_next       = day_reg;
        rec_valid_next = rec_valid_reg && !rec_take;
        rec_next       = rec_reg;
        if (s_accept) begin
            if (s_last) begin
                pos_next       = '0;
                bad_next       = 1'b0;
                year_next      = '0;
                year_hi_next   = '0;
                year_lo_next   = '0;
                month_next     = '0;
                day_next       = '0;
                rec_valid_next = 1'b1;
                rec_next.len_ok  = (step_pos == POS_DATE_LEN);
                rec_next.fmt_bad = step_bad;
                // lo holds year mod 100, hi holds year / 100
                rec_next.leap    = (step_lo == '0) ? (step_hi[1:0] == 2'd0)
                                                   : (step_lo[1:0] == 2'd0);
                rec_next.year    = step_year;
                rec_next.month   = step_month;
                rec_next.day     = step_day;
            end else begin
                pos_next     = step_pos;
                bad_next     = step_bad;
                year_next    = step_year;
                year_hi_next = step_hi;
                year_lo_next = step_lo;
                month_next   = step_month;
                day_next     = step_day;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            bad_reg       <= 1'b0;
            year_reg      <= '0;
            year_hi_reg   <= '0;
            year_lo_reg   <= '0;
            month_reg     <= '0;
            day_reg       <= '0;
            rec_valid_reg <= 1'b0;
        end else begin
            pos_reg       <= pos_next;
            bad_reg       <= bad_next;
            year_reg      <= year_next;
            year_hi_reg   <= year_hi_next;
            year_lo_reg   <= year_lo_next;
            month_reg     <= month_next;
            day_reg       <= day_next;
            rec_valid_reg <= rec_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rec_reg <= rec_next;
    end

    assign rec_valid = rec_valid_reg;
    assign rec       = rec_reg;

    p_pos_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= POS_SAT)
        else $error("position count past saturation");

    p_rec_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (rec_valid_reg && !rec_take) |=> (rec_valid_reg && $stable(rec_reg)))
        else $error("pending date record lost");

    p_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_last) |=> (pos_reg == '0 && !bad_reg && rec_valid_reg))
        else $error("parser state not cleared after last beat");

endmodule

>>> hw/rtl/dsv_check.sv
// Date value check and result register: range, calendar and age tests.
// Takes the parser record and the current-date settings. Depends on dsv_pkg.
module dsv_check import dsv_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                rec_valid,
    input  date_rec_t           rec,
    output logic                rec_take,
    input  today_cfg_t          today,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [STATUS_W-1:0] m_status,
    output logic                m_older,
    output logic [YEAR_W-1:0]   m_year_out,
    output logic [MD_W-1:0]     m_month_out,
    output logic [MD_W-1:0]     m_day_out
);

    logic                m_valid_reg,  m_valid_next;
    logic [STATUS_W-1:0] m_status_reg, m_status_next;
    logic                m_older_reg,  m_older_next;
    logic [YEAR_W-1:0]   m_year_reg,   m_year_next;
    logic [MD_W-1:0]     m_month_reg,  m_month_next;
    logic [MD_W-1:0]     m_day_reg,    m_day_next;

    logic [MD_W-1:0]   t_month, t_day, month_len;
    logic              values_bad, older;
    logic signed [YEAR_W:0] age_diff, age_lim;

    assign rec_take = !m_valid_reg || m_ready;
    assign t_month  = {{(MD_W-TMONTH_W){1'b0}}, today.month};
    assign t_day    = {{(MD_W-TDAY_W){1'b0}}, today.day};

    always_comb begin
        case (rec.month) inside
            MONTH_FEB:              month_len = rec.leap ? DAYS_29 : DAYS_28;
            7'd4, 7'd6, 7'd9, 7'd11: month_len = DAYS_30;
            default:                month_len = DAYS_31;
        endcase
    end

    always_comb begin
        values_bad = (rec.year == '0) || (rec.year > today.year)
                  || (rec.month == '0) || (rec.month > MONTHS_PER_YEAR)
                  || ((rec.year == today.year) && (rec.month > t_month))
                  || (rec.day == '0)
                  || ((rec.year == today.year) && (rec.month == t_month)
                      && (rec.day > t_day))
                  || (rec.day > month_len);
    end

    assign age_diff = $signed({1'b0, today.year}) - $signed({1'b0, rec.year});
    assign age_lim  = $signed({{(YEAR_W+1-AGE_W){1'b0}}, today.age_limit});

    always_comb begin
        if (age_diff > age_lim) begin
            older = 1'b1;
        end else if (age_diff < age_lim) begin
            older = 1'b0;
        end else if (rec.month != t_month) begin
            older = rec.month < t_month;
        end else begin
            older = rec.day < t_day;
        end
    end

    always_comb begin
        m_valid_next  = m_valid_reg && !m_ready;
        m_status_next = m_status_reg;
        m_older_next  = m_older_reg;
        m_year_next   = m_year_reg;
        m_month_next  = m_month_reg;
        m_day_next    = m_day_reg;
        if (rec_valid && rec_take) begin
            m_valid_next = 1'b1;
            if (!rec.len_ok) begin
                m_status_next = ST_LENGTH;
                m_older_next  = 1'b0;
                m_year_next   = '0;
                m_month_next  = '0;
                m_day_next    = '0;
            end else begin
                m_status_next = (rec.fmt_bad || values_bad) ? ST_BAD : ST_OK;
                m_older_next  = older;
                m_year_next   = rec.year;
                m_month_next  = rec.month;
                m_day_next    = rec.day;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_status_reg <= m_status_next;
        m_older_reg  <= m_older_next;
        m_year_reg   <= m_year_next;
        m_month_reg  <= m_month_next;
        m_day_reg    <= m_day_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_older     = m_older_reg;
    assign m_year_out  = m_year_reg;
    assign m_month_out = m_month_reg;
    assign m_day_out   = m_day_reg;

    p_len_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_status_reg == ST_LENGTH)
        |-> (!m_older_reg && m_year_reg == '0 && m_month_reg == '0 && m_day_reg == '0))
        else $error("wrong-length beat carries nonzero fields");

    p_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_status_reg == ST_OK || m_status_reg == ST_LENGTH
                         || m_status_reg == ST_BAD))
        else $error("undefined status code");

    p_rec_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        (rec_valid && rec_take) |=> m_valid_reg)
        else $error("record taken but no result beat");

endmodule

>>> hw/rtl/date_string_validator.sv
// Date string validator: takes YYYY.MM.DD one character per beat and gives one
// result beat per string (status, older flag, parsed fields), registered in
// the parse stage, then in the check stage. Characters are accepted one per
// clock, set by the single parse stage, while s_ready is high; a result waiting
// on m_ready stalls the input only once the date record behind it is also held.
// Settings are to be written through the cfg port while the block is idle; the
// block does not enforce this. Uses dsv_pkg, dsv_parse and dsv_check.
module date_string_validator import dsv_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [CH_W-1:0]       s_ch,
    input  logic                  s_last,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [STATUS_W-1:0]   m_status,
    output logic                  m_older,
    output logic [YEAR_W-1:0]     m_year_out,
    output logic [MD_W-1:0]       m_month_out,
    output logic [MD_W-1:0]       m_day_out
);

    today_cfg_t today_reg, today_next;
    logic       rec_valid, rec_take;
    date_rec_t  rec;

    assign cfg_ready = 1'b1;

    always_comb begin
        today_next = today_reg;
        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_TODAY_YEAR:  today_next.year      = cfg_data[YEAR_W-1:0];
                CFG_TODAY_MONTH: today_next.month     = cfg_data[TMONTH_W-1:0];
                CFG_TODAY_DAY:   today_next.day       = cfg_data[TDAY_W-1:0];
                CFG_AGE_LIMIT:   today_next.age_limit = cfg_data[AGE_W-1:0];
                default:         today_next = today_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            today_reg.year      <= RST_TODAY_YEAR;
            today_reg.month     <= RST_TODAY_MONTH;
            today_reg.day       <= RST_TODAY_DAY;
            today_reg.age_limit <= RST_AGE_LIMIT;
        end else begin
            today_reg <= today_next;
        end
    end

    dsv_parse u_parse (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_ch      (s_ch),
        .s_last    (s_last),
        .rec_valid (rec_valid),
        .rec       (rec),
        .rec_take  (rec_take)
    );

    dsv_check u_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .rec_valid   (rec_valid),
        .rec         (rec),
        .rec_take    (rec_take),
        .today       (today_reg),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_older     (m_older),
        .m_year_out  (m_year_out),
        .m_month_out (m_month_out),
        .m_day_out   (m_day_out)
    );

endmodule
